FILE: rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

FILE: rtl/ufb_pkg.sv
`timescale 1ns / 1ps

package ufb_pkg;

  localparam int BUFFER_DEPTH     = 128;
  localparam int IDX_W            = $clog2(BUFFER_DEPTH);
  localparam int CNT_W            = IDX_W + 1;
  localparam int DATA_W           = 8;
  localparam int TIMER_W          = 8;
  localparam int LEN_W            = 8;
  localparam int IDLE_TICKS_RESET = 5;

  typedef enum logic [2:0] {
    KIND_RX_BYTE  = 3'd0,
    KIND_TICK     = 3'd1,
    KIND_TAKE     = 3'd2,
    KIND_READ_RX  = 3'd3,
    KIND_WRITE_TX = 3'd4,
    KIND_START_TX = 3'd5,
    KIND_TX_READY = 3'd6
  } kind_t;

endpackage

FILE: rtl/uart_frame_buffer_with_idle_timeout_unit.sv
`timescale 1ns / 1ps

// Channel   | Ports                                             | Direction
// ----------+---------------------------------------------------+----------
// input     | in_valid, in_stall, in_kind/data/index/length     | in
// result    | out_valid, out_stall, out_tx_valid ... out_tx_busy| out
// config    | cfg_we, cfg_wdata (idle_ticks)                    | in
//
// One word in, one word out; a new word is taken every cycle unless stalled.
// A word passes the input register, then the state update with the buffer
// read, whose registered data is muxed straight onto the result outputs.
// Reset (rst_n low, synchronous) clears counters, state flags and handshake
// valids; result fields and buffer contents are undefined until written.
// A stalled result holds; the input register holds one more word behind it.

`include "assert_macros.svh"

module uart_frame_buffer_with_idle_timeout_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_kind,
  input  logic [ufb_pkg::DATA_W-1:0]  in_data,
  input  logic [ufb_pkg::IDX_W-1:0]   in_index,
  input  logic [ufb_pkg::LEN_W-1:0]   in_length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_tx_valid,
  output logic [ufb_pkg::DATA_W-1:0]  out_tx_data,
  output logic                        out_frame_ready,
  output logic [ufb_pkg::CNT_W-1:0]   out_frame_length,
  output logic [ufb_pkg::DATA_W-1:0]  out_read_data,
  output logic                        out_tx_busy,
  input  logic                        cfg_we,
  input  logic [ufb_pkg::TIMER_W-1:0] cfg_wdata
);

  localparam logic [ufb_pkg::CNT_W-1:0] DEPTH_CNT = ufb_pkg::CNT_W'(ufb_pkg::BUFFER_DEPTH);

  // Input register
  logic                        s1_valid_r;
  ufb_pkg::kind_t              s1_kind_r;
  logic [ufb_pkg::DATA_W-1:0]  s1_data_r;
  logic [ufb_pkg::IDX_W-1:0]   s1_index_r;
  logic [ufb_pkg::LEN_W-1:0]   s1_length_r;

  // Block state
  logic [ufb_pkg::TIMER_W-1:0] idle_ticks_r;
  logic [ufb_pkg::CNT_W-1:0]   rx_count_r, rx_count_nxt;
  logic [ufb_pkg::TIMER_W-1:0] idle_timer_r, idle_timer_nxt;
  logic                        frame_done_r, frame_done_nxt;
  logic [ufb_pkg::IDX_W-1:0]   tx_pos_r, tx_pos_nxt;
  logic [ufb_pkg::CNT_W-1:0]   tx_remaining_r, tx_remaining_nxt;

  // Buffers
  logic [ufb_pkg::DATA_W-1:0]  rx_mem [ufb_pkg::BUFFER_DEPTH];
  logic [ufb_pkg::DATA_W-1:0]  tx_mem [ufb_pkg::BUFFER_DEPTH];
  logic [ufb_pkg::DATA_W-1:0]  rx_rd_r, tx_rd_r;

  // Result register
  logic                        out_valid_r;
  logic                        out_tx_valid_r, out_tx_valid_nxt;
  logic                        out_frame_ready_r, out_frame_ready_nxt;
  logic [ufb_pkg::CNT_W-1:0]   out_frame_length_r, out_frame_length_nxt;
  logic                        out_rd_sel_r;
  logic                        out_tx_busy_r;

  logic                        advance;
  logic                        fire;
  logic                        rx_we;
  logic [ufb_pkg::IDX_W-1:0]   rx_waddr;
  logic                        tx_we;
  logic [ufb_pkg::TIMER_W-1:0] timer_dec;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_kind_r   <= ufb_pkg::kind_t'(in_kind);
      s1_data_r   <= in_data;
      s1_index_r  <= in_index;
      s1_length_r <= in_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_ticks_r <= ufb_pkg::TIMER_W'(ufb_pkg::IDLE_TICKS_RESET);
    end else if (cfg_we) begin
      idle_ticks_r <= cfg_wdata;
    end
  end

  assign timer_dec = idle_timer_r - 1'b1;

  always_comb begin
    rx_count_nxt         = rx_count_r;
    idle_timer_nxt       = idle_timer_r;
    frame_done_nxt       = frame_done_r;
    tx_pos_nxt           = tx_pos_r;
    tx_remaining_nxt     = tx_remaining_r;
    rx_we                = 1'b0;
    rx_waddr             = (rx_count_r >= DEPTH_CNT) ? '0 : rx_count_r[ufb_pkg::IDX_W-1:0];
    tx_we                = 1'b0;
    out_tx_valid_nxt     = 1'b0;
    out_frame_length_nxt = '0;
    unique case (s1_kind_r)
      ufb_pkg::KIND_RX_BYTE: begin
        // drop the byte while a finished frame waits to be taken
        if (!frame_done_r) begin
          rx_we        = 1'b1;
          rx_count_nxt = {1'b0, rx_waddr} + 1'b1;
        end
        idle_timer_nxt = idle_ticks_r;
      end
      ufb_pkg::KIND_TICK: begin
        if (idle_timer_r != '0) begin
          idle_timer_nxt = timer_dec;
          if (timer_dec == '0 && rx_count_r != '0) begin
            frame_done_nxt = 1'b1;
          end
        end
      end
      ufb_pkg::KIND_TAKE: begin
        if (frame_done_r) begin
          frame_done_nxt = 1'b0;
          rx_count_nxt   = '0;
        end
      end
      ufb_pkg::KIND_WRITE_TX: begin
        tx_we = 1'b1;
      end
      ufb_pkg::KIND_START_TX: begin
        tx_remaining_nxt = (ufb_pkg::CNT_W'(s1_length_r) > DEPTH_CNT) ? DEPTH_CNT
                                                                       : ufb_pkg::CNT_W'(s1_length_r);
      end
      ufb_pkg::KIND_TX_READY: begin
        if (tx_remaining_r != '0) begin
          out_tx_valid_nxt = 1'b1;
          tx_pos_nxt       = tx_pos_r + 1'b1;
          tx_remaining_nxt = tx_remaining_r - 1'b1;
        end else begin
          tx_pos_nxt = '0;
        end
      end
      default: begin
      end
    endcase
    // a take that succeeds reports the old count, else the count after the word
    if (s1_kind_r == ufb_pkg::KIND_TAKE && frame_done_r) begin
      out_frame_ready_nxt  = 1'b1;
      out_frame_length_nxt = rx_count_r;
    end else begin
      out_frame_ready_nxt  = frame_done_nxt;
      out_frame_length_nxt = rx_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_count_r     <= '0;
      idle_timer_r   <= '0;
      frame_done_r   <= 1'b0;
      tx_pos_r       <= '0;
      tx_remaining_r <= '0;
    end else if (fire) begin
      rx_count_r     <= rx_count_nxt;
      idle_timer_r   <= idle_timer_nxt;
      frame_done_r   <= frame_done_nxt;
      tx_pos_r       <= tx_pos_nxt;
      tx_remaining_r <= tx_remaining_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && rx_we) begin
      rx_mem[rx_waddr] <= s1_data_r;
    end
    if (fire) begin
      rx_rd_r <= rx_mem[s1_index_r];
    end
  end

  always_ff @(posedge clk) begin
    if (fire && tx_we) begin
      tx_mem[s1_index_r] <= s1_data_r;
    end
    if (fire) begin
      tx_rd_r <= tx_mem[tx_pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_tx_valid_r     <= out_tx_valid_nxt;
      out_frame_ready_r  <= out_frame_ready_nxt;
      out_frame_length_r <= out_frame_length_nxt;
      out_rd_sel_r       <= (s1_kind_r == ufb_pkg::KIND_READ_RX);
      out_tx_busy_r      <= (tx_remaining_nxt != '0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tx_valid     = out_tx_valid_r;
  assign out_tx_data      = out_tx_valid_r ? tx_rd_r : '0;
  assign out_frame_ready  = out_frame_ready_r;
  assign out_frame_length = out_frame_length_r;
  assign out_read_data    = out_rd_sel_r ? rx_rd_r : '0;
  assign out_tx_busy      = out_tx_busy_r;

  `ASSERT_ALWAYS(a_rx_count_range, rx_count_r <= DEPTH_CNT, "rx count beyond buffer depth")
  `ASSERT_ALWAYS(a_done_has_bytes, !frame_done_r || rx_count_r != '0, "frame done, no bytes")
  `ASSERT_ALWAYS(a_tx_rem_range, tx_remaining_r <= DEPTH_CNT, "tx remaining beyond buffer depth")
  `ASSERT_NEXT(a_s1_hold, s1_valid_r && !advance, s1_valid_r, "input register lost a word")

endmodule

FILE: test/ufb_checker.sv
`timescale 1ns / 1ps

module ufb_checker
  import ufb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [2:0]          in_kind,
  input  logic [DATA_W-1:0]   in_data,
  input  logic [IDX_W-1:0]    in_index,
  input  logic [LEN_W-1:0]    in_length,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic                out_tx_valid,
  input  logic [DATA_W-1:0]   out_tx_data,
  input  logic                out_frame_ready,
  input  logic [CNT_W-1:0]    out_frame_length,
  input  logic [DATA_W-1:0]   out_read_data,
  input  logic                out_tx_busy,
  input  logic                cfg_we,
  input  logic [TIMER_W-1:0]  cfg_wdata,
  output int                  outstanding,
  output int                  err_count,
  output int                  checked_words
);

  typedef struct packed {
    logic              tx_valid;
    logic [DATA_W-1:0] tx_data;
    logic              frame_ready;
    logic [CNT_W-1:0]  frame_length;
    logic [DATA_W-1:0] read_data;
    logic              tx_busy;
  } status_t;

  logic [DATA_W-1:0]  rx_mem [BUFFER_DEPTH];
  logic [DATA_W-1:0]  tx_mem [BUFFER_DEPTH];
  int                 rx_fill;
  int                 silence_left;
  bit                 frame_pending;
  int                 send_pos;
  int                 send_left;
  logic [TIMER_W-1:0] idle_limit;
  status_t            expected_q[$];

  initial begin
    outstanding   = 0;
    err_count     = 0;
    checked_words = 0;
  end

  // Apply one input word to the shadow state and return the status it produces.
  function automatic status_t apply_word(logic [2:0] kind, logic [DATA_W-1:0] data,
                                         logic [IDX_W-1:0] idx, logic [LEN_W-1:0] len);
    status_t r;
    bit      taken;
    int      taken_len;
    r         = '0;
    taken     = 0;
    taken_len = 0;
    case (kind)
      KIND_RX_BYTE: begin
        if (!frame_pending) begin
          if (rx_fill >= BUFFER_DEPTH) rx_fill = 0;
          rx_mem[rx_fill] = data;
          rx_fill++;
        end
        silence_left = int'(idle_limit);
      end
      KIND_TICK: begin
        if (silence_left != 0) begin
          silence_left--;
          if (silence_left == 0 && rx_fill > 0) frame_pending = 1;
        end
      end
      KIND_TAKE: begin
        if (frame_pending) begin
          taken         = 1;
          taken_len     = rx_fill;
          frame_pending = 0;
          rx_fill       = 0;
        end
      end
      KIND_READ_RX:  r.read_data = rx_mem[idx];
      KIND_WRITE_TX: tx_mem[idx] = data;
      KIND_START_TX: send_left = (len > BUFFER_DEPTH) ? BUFFER_DEPTH : int'(len);
      KIND_TX_READY: begin
        if (send_left != 0) begin
          if (send_pos >= BUFFER_DEPTH) send_pos = 0;
          r.tx_valid = 1'b1;
          r.tx_data  = tx_mem[send_pos];
          send_pos++;
          if (send_pos >= BUFFER_DEPTH) send_pos = 0;
          send_left--;
        end else begin
          send_pos = 0;
        end
      end
      default: ;
    endcase
    r.frame_ready  = taken || frame_pending;
    r.frame_length = CNT_W'(taken ? taken_len : rx_fill);
    r.tx_busy      = (send_left != 0);
    return r;
  endfunction

  function automatic int field_check(string fname, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : monitor
    status_t want;
    int      bad;
    bad = 0;
    if (!rst_n) begin
      rx_fill       = 0;
      silence_left  = 0;
      frame_pending = 0;
      send_pos      = 0;
      send_left     = 0;
      idle_limit    = TIMER_W'(IDLE_TICKS_RESET);
      expected_q.delete();
      outstanding   <= 0;
      err_count     <= 0;
      checked_words <= 0;
    end else begin
      if (cfg_we) idle_limit = cfg_wdata;
      if (in_valid && !in_stall)
        expected_q.push_back(apply_word(in_kind, in_data, in_index, in_length));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word, tx_data %0d frame_length %0d read_data %0d",
                   $time, out_tx_data, out_frame_length, out_read_data);
          bad++;
        end else begin
          want = expected_q.pop_front();
          bad += field_check("tx_valid", want.tx_valid, out_tx_valid);
          bad += field_check("tx_data", want.tx_data, out_tx_data);
          bad += field_check("frame_ready", want.frame_ready, out_frame_ready);
          bad += field_check("frame_length", want.frame_length, out_frame_length);
          bad += field_check("read_data", want.read_data, out_read_data);
          bad += field_check("tx_busy", want.tx_busy, out_tx_busy);
          checked_words <= checked_words + 1;
        end
      end
      outstanding <= expected_q.size();
      err_count   <= err_count + bad;
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import ufb_pkg::*;

  localparam logic [2:0] KIND_SPARE = 3'd7;

  logic               clk;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic [2:0]         in_kind    = '0;
  logic [DATA_W-1:0]  in_data    = '0;
  logic [IDX_W-1:0]   in_index   = '0;
  logic [LEN_W-1:0]   in_length  = '0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic               out_tx_valid;
  logic [DATA_W-1:0]  out_tx_data;
  logic               out_frame_ready;
  logic [CNT_W-1:0]   out_frame_length;
  logic [DATA_W-1:0]  out_read_data;
  logic               out_tx_busy;
  logic               cfg_we     = 1'b0;
  logic [TIMER_W-1:0] cfg_wdata  = '0;

  int outstanding;
  int err_count;
  int checked_words;
  int words_sent   = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int cur_idle     = IDLE_TICKS_RESET;

  uart_frame_buffer_with_idle_timeout_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_data          (in_data),
    .in_index         (in_index),
    .in_length        (in_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tx_valid     (out_tx_valid),
    .out_tx_data      (out_tx_data),
    .out_frame_ready  (out_frame_ready),
    .out_frame_length (out_frame_length),
    .out_read_data    (out_read_data),
    .out_tx_busy      (out_tx_busy),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  ufb_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_data          (in_data),
    .in_index         (in_index),
    .in_length        (in_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tx_valid     (out_tx_valid),
    .out_tx_data      (out_tx_data),
    .out_frame_ready  (out_frame_ready),
    .out_frame_length (out_frame_length),
    .out_read_data    (out_read_data),
    .out_tx_busy      (out_tx_busy),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .outstanding      (outstanding),
    .err_count        (err_count),
    .checked_words    (checked_words)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("uart_frame_buffer_with_idle_timeout_unit verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  function automatic logic [DATA_W-1:0] rnd_data();
    return DATA_W'($urandom_range(255));
  endfunction

  function automatic logic [IDX_W-1:0] rnd_idx();
    return IDX_W'($urandom_range(127));
  endfunction

  function automatic logic [LEN_W-1:0] rnd_len();
    return LEN_W'($urandom_range(255));
  endfunction

  task automatic send_word(logic [2:0] kind, logic [DATA_W-1:0] data,
                           logic [IDX_W-1:0] idx, logic [LEN_W-1:0] len);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_data   <= data;
    in_index  <= idx;
    in_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Drop valid and hold until every expected result word has come back.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_idle_ticks(logic [TIMER_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_idle  = int'(value);
  endtask

  task automatic rx_frame;
    int n;
    int ticks;
    n = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    repeat (n) begin
      send_word(KIND_RX_BYTE, rnd_data(), rnd_idx(), rnd_len());
      if ($urandom_range(7) == 0)
        send_word(KIND_TICK, rnd_data(), rnd_idx(), rnd_len());
    end
    if (cur_idle <= 16)
      ticks = $urandom_range(cur_idle + 2);
    else
      ticks = ($urandom_range(2) == 0) ? cur_idle : $urandom_range(8);
    repeat (ticks)
      send_word(KIND_TICK, rnd_data(), rnd_idx(), rnd_len());
    send_word(KIND_TAKE, rnd_data(), rnd_idx(), rnd_len());
    repeat ($urandom_range(3))
      send_word(KIND_READ_RX, rnd_data(), rnd_idx(), rnd_len());
  endtask

  task automatic tx_burst;
    int len;
    int sends;
    repeat ($urandom_range(6))
      send_word(KIND_WRITE_TX, rnd_data(), rnd_idx(), rnd_len());
    len   = ($urandom_range(9) == 0) ? $urandom_range(128, 255) : $urandom_range(10);
    sends = ((len > BUFFER_DEPTH) ? BUFFER_DEPTH : len) + $urandom_range(2);
    send_word(KIND_START_TX, rnd_data(), rnd_idx(), LEN_W'(len));
    repeat (sends)
      send_word(KIND_TX_READY, rnd_data(), rnd_idx(), rnd_len());
  endtask

  task automatic random_phase(logic [TIMER_W-1:0] ticks_cfg, int snd_pct, int rcv_pct,
                              int target);
    int start;
    int pick;
    write_idle_ticks(ticks_cfg);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    start = words_sent;
    while (words_sent - start < target) begin
      pick = $urandom_range(99);
      if (pick < 45)
        rx_frame();
      else if (pick < 75)
        tx_burst();
      else
        send_word(3'($urandom_range(7)), rnd_data(), rnd_idx(), rnd_len());
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill both stores so that no later read or send touches an unwritten entry.
    for (int i = 0; i < BUFFER_DEPTH; i++)
      send_word(KIND_WRITE_TX, rnd_data(), IDX_W'(i), 8'h00);
    for (int i = 0; i < BUFFER_DEPTH; i++)
      send_word(KIND_RX_BYTE, rnd_data(), 7'h00, 8'h00);

    // Buffer is full: the next byte wraps to the start.
    send_word(KIND_RX_BYTE, 8'hFF, 7'h7F, 8'hFF);
    send_word(KIND_READ_RX, 8'h00, 7'h00, 8'h00);
    send_word(KIND_READ_RX, 8'hFF, 7'h7F, 8'hFF);
    send_word(KIND_TAKE, 8'h00, 7'h00, 8'h00);
    repeat (IDLE_TICKS_RESET) send_word(KIND_TICK, 8'h00, 7'h00, 8'h00);
    // Byte arriving while a frame is pending is dropped.
    send_word(KIND_RX_BYTE, 8'h00, 7'h00, 8'h00);
    send_word(KIND_TAKE, 8'h00, 7'h00, 8'h00);
    send_word(KIND_TAKE, 8'h00, 7'h00, 8'h00);
    send_word(KIND_WRITE_TX, 8'hFF, 7'h7F, 8'h00);
    send_word(KIND_WRITE_TX, 8'h00, 7'h00, 8'h00);
    send_word(KIND_START_TX, 8'h00, 7'h00, 8'hFF);
    repeat (2) send_word(KIND_TX_READY, 8'h00, 7'h00, 8'h00);
    send_word(KIND_START_TX, 8'h00, 7'h00, 8'h00);
    send_word(KIND_TX_READY, 8'h00, 7'h00, 8'h00);
    send_word(KIND_START_TX, 8'h00, 7'h00, 8'd1);
    send_word(KIND_TX_READY, 8'h00, 7'h00, 8'h00);
    send_word(KIND_SPARE, 8'hFF, 7'h7F, 8'hFF);
    // A zero timeout never closes a frame.
    write_idle_ticks(8'd0);
    send_word(KIND_RX_BYTE, 8'h5A, 7'h00, 8'h00);
    repeat (2) send_word(KIND_TICK, 8'h00, 7'h00, 8'h00);
    send_word(KIND_TAKE, 8'h00, 7'h00, 8'h00);

    random_phase(8'd1, 36, 75, 50);
    random_phase(8'd20, 75, 36, 50);
    random_phase(8'd3, 0, 0, 50);

    drain();
    repeat (4) @(posedge clk);
    $display("Sent %0d input words and checked %0d result words;", words_sent, checked_words);
    $display("idle timeouts 5, 0, 1, 20 and 3 under three flow-control mixes.");
    if (err_count == 0 && outstanding == 0) begin
      $display("uart_frame_buffer_with_idle_timeout_unit verification clean");
    end else begin
      $display("uart_frame_buffer_with_idle_timeout_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/ufb_pkg.sv
rtl/uart_frame_buffer_with_idle_timeout_unit.sv
test/ufb_checker.sv
test/tb.sv
